### sv/skyline_merge_engine_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the skyline merge engine
// Clocked, reset-gated property forms shared by the checker.
// ---------------------------------------------------------------------------
`ifndef SKYLINE_MERGE_ENGINE_MACROS_SVH
`define SKYLINE_MERGE_ENGINE_MACROS_SVH

// same-cycle implication
`define SME_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("skyline_merge_engine: same-cycle check failed");

// next-cycle implication
`define SME_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("skyline_merge_engine: next-cycle check failed");

`endif

### sv/sme_pkg.sv
// ---------------------------------------------------------------------------
// Skyline merge engine package
// Sizes, payload types and helpers shared by the engine files.
// ---------------------------------------------------------------------------
package sme_pkg;

    localparam int MAX_BUILDINGS = 16;
    localparam int BLD_IDX_W     = $clog2(MAX_BUILDINGS);
    localparam int BLD_CNT_W     = $clog2(MAX_BUILDINGS + 1);
    localparam int STRIP_CAP     = 2 * MAX_BUILDINGS;
    localparam int STRIP_AW      = $clog2(STRIP_CAP);
    localparam int LEN_W         = $clog2(STRIP_CAP + 1);
    localparam int COORD_W       = 16;
    localparam int FSTK_D        = 16;
    localparam int FSTK_W        = $clog2(FSTK_D);

    typedef logic [COORD_W-1:0] t_coord;

    typedef struct packed {
        t_coord right;
        t_coord height;
        t_coord left;
    } t_bldg;

    typedef struct packed {
        t_coord height;
        t_coord x;
    } t_strip;

    typedef struct packed {
        logic             bank;
        logic [LEN_W-1:0] len;
    } t_seg;

endpackage

### sv/sme_bldg_if.sv
// ---------------------------------------------------------------------------
// Building channel
// Valid/ready channel carrying one building per beat.
// ---------------------------------------------------------------------------
interface sme_bldg_if import sme_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord bldg_left;
    t_coord bldg_height;
    t_coord bldg_right;
    logic   final_bldg;

    modport source (output valid, bldg_left, bldg_height, bldg_right, final_bldg,
                    input ready);
    modport sink   (input valid, bldg_left, bldg_height, bldg_right, final_bldg,
                    output ready);
endinterface

### sv/sme_strip_if.sv
// ---------------------------------------------------------------------------
// Strip channel
// Valid/ready channel carrying one skyline strip per beat.
// ---------------------------------------------------------------------------
interface sme_strip_if import sme_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord strip_x;
    t_coord strip_height;
    logic   final_strip;

    modport source (output valid, strip_x, strip_height, final_strip, input ready);
    modport sink   (input valid, strip_x, strip_height, final_strip, output ready);
endinterface

### sv/sme_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module sme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### sv/skyline_merge_engine.sv
// ---------------------------------------------------------------------------
// Skyline merge engine
// Loads buildings, merges their skylines along a halving tree, emits strips.
//
//   channel   dir  payload                                   beat
//   i_bldg    in   bldg_left, bldg_height, bldg_right, final  one building
//   o_strip   out  strip_x, strip_height, final_strip         one strip
//
// Loading accepts one building per cycle. After the final building, each leaf
// writes its strips, each merge loads strips one at a time through the one
// read port of each bank, and each output strip is held until o_strip
// takes it. No input beat is taken while a set is merged or emitted.
// Reset needs no clearing pass.
// ---------------------------------------------------------------------------
module skyline_merge_engine import sme_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sme_bldg_if.sink    i_bldg,
    sme_strip_if.source o_strip
);
    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_NODE   = 5'd1;
    localparam logic [4:0] S_LF_RD  = 5'd2;
    localparam logic [4:0] S_LF_W1  = 5'd3;
    localparam logic [4:0] S_LF_W2  = 5'd4;
    localparam logic [4:0] S_MG_L1  = 5'd5;
    localparam logic [4:0] S_MG_L2  = 5'd6;
    localparam logic [4:0] S_MG_L3  = 5'd7;
    localparam logic [4:0] S_FILL   = 5'd8;
    localparam logic [4:0] S_LDA    = 5'd9;
    localparam logic [4:0] S_LDB    = 5'd10;
    localparam logic [4:0] S_PUT    = 5'd11;
    localparam logic [4:0] S_OUT_L1 = 5'd12;
    localparam logic [4:0] S_OUT_L2 = 5'd13;
    localparam logic [4:0] S_OUT_RD = 5'd14;
    localparam logic [4:0] S_OUT_LD = 5'd15;
    localparam logic [4:0] S_OUT_WT = 5'd16;

    logic [4:0]           r_state;
    logic [BLD_CNT_W-1:0] r_cnt;

    // range frames of the tree walk
    logic [BLD_IDX_W-1:0] r_fs_lo [FSTK_D];
    logic [BLD_IDX_W-1:0] r_fs_hi [FSTK_D];
    logic                 r_fs_ph [FSTK_D];
    logic [FSTK_W-1:0]    r_sp;

    logic [BLD_IDX_W-1:0] r_lo;
    logic [BLD_IDX_W-1:0] r_mid;
    t_bldg                r_bld;

    logic [LEN_W-1:0]     r_na, r_nb, r_i, r_j, r_n;
    logic                 r_pa, r_pb;
    logic                 r_a_ok, r_b_ok;
    t_strip               r_a, r_b;
    t_coord               r_h1, r_h2;
    t_coord               r_last_x, r_last_h;

    logic [LEN_W-1:0]     r_tot, r_k;
    logic                 r_obank;
    logic                 r_o_valid;
    t_strip               r_o_strip;
    logic                 r_o_final;

    // memory ports
    logic                 bld_we;
    logic [BLD_IDX_W-1:0] bld_waddr, bld_raddr;
    t_bldg                bld_wdata, bld_rdata;
    logic                 sa_we, sb_we;
    logic [STRIP_AW-1:0]  st_waddr, st_raddr;
    t_strip               st_wdata, sa_rdata, sb_rdata;
    logic                 seg_we;
    logic [BLD_IDX_W-1:0] seg_waddr, seg_raddr;
    t_seg                 seg_wdata, seg_rdata;

    logic                 in_acc;
    logic [FSTK_W-1:0]    top;
    logic [BLD_IDX_W-1:0] t_lo_w, t_hi_w, t_mid_w;
    logic [BLD_IDX_W:0]   lohi_sum;
    logic [STRIP_AW-1:0]  a_base, b_base;
    logic                 leaf2;

    // merge step decode
    logic                 put_req, put_done, put_take_a, put_take_b;
    t_coord               put_x, put_h;
    logic                 put_skip, put_fold;
    t_coord               fold_h;
    logic [LEN_W-1:0]     put_addr;

    assign in_acc   = i_bldg.valid && i_bldg.ready;
    assign top      = r_sp - 1'b1;
    assign t_lo_w   = r_fs_lo[top];
    assign t_hi_w   = r_fs_hi[top];
    assign lohi_sum = {1'b0, t_lo_w} + {1'b0, t_hi_w};
    assign t_mid_w  = lohi_sum[BLD_IDX_W:1];
    assign a_base   = {r_lo, 1'b0};
    assign b_base   = {r_mid + 1'b1, 1'b0};
    assign leaf2    = (r_bld.height != '0) && (r_bld.right != r_bld.left);

    always_comb begin
        put_take_a = 1'b0;
        put_take_b = 1'b0;
        put_x      = r_a.x;
        put_h      = r_a.height;
        if (r_a_ok && r_b_ok) begin
            if (r_a.x < r_b.x) begin
                put_take_a = 1'b1;
                put_x      = r_a.x;
                put_h      = (r_a.height > r_h2) ? r_a.height : r_h2;
            end else begin
                put_take_b = 1'b1;
                put_x      = r_b.x;
                put_h      = (r_h1 > r_b.height) ? r_h1 : r_b.height;
            end
        end else if (r_a_ok) begin
            put_take_a = 1'b1;
        end else if (r_b_ok) begin
            put_take_b = 1'b1;
            put_x      = r_b.x;
            put_h      = r_b.height;
        end
        put_req  = put_take_a || put_take_b;
        put_done = !put_req;
        put_skip = (r_n != '0) && (r_last_h == put_h);
        put_fold = (r_n != '0) && !put_skip && (r_last_x == put_x);
        fold_h   = (put_h > r_last_h) ? put_h : r_last_h;
        put_addr = {1'b0, a_base} + (put_fold ? r_n - 1'b1 : r_n);
    end

    always_comb begin
        bld_we    = in_acc && (r_cnt < BLD_CNT_W'(MAX_BUILDINGS));
        bld_waddr = r_cnt[BLD_IDX_W-1:0];
        bld_wdata = '{right: i_bldg.bldg_right, height: i_bldg.bldg_height,
                      left: i_bldg.bldg_left};
        bld_raddr = r_lo;

        sa_we     = 1'b0;
        sb_we     = 1'b0;
        st_waddr  = a_base;
        st_wdata  = '{height: r_bld.height, x: r_bld.left};
        st_raddr  = r_k[STRIP_AW-1:0];
        seg_we    = 1'b0;
        seg_waddr = r_lo;
        seg_wdata = '{bank: 1'b0, len: leaf2 ? LEN_W'(2) : LEN_W'(1)};
        seg_raddr = r_lo;

        case (r_state)
            S_LF_W1: begin
                // building word arrives this cycle, write the rising strip from it
                sa_we    = 1'b1;
                st_wdata = '{height: bld_rdata.height, x: bld_rdata.left};
            end
            S_LF_W2: begin
                sa_we    = leaf2;
                st_waddr = a_base + 1'b1;
                st_wdata = '{height: '0, x: r_bld.right};
                seg_we   = 1'b1;
            end
            S_MG_L2: begin
                seg_raddr = r_mid + 1'b1;
            end
            S_FILL: begin
                if (r_i < r_na && !r_a_ok) begin
                    st_raddr = a_base + r_i[STRIP_AW-1:0];
                end else begin
                    st_raddr = b_base + r_j[STRIP_AW-1:0];
                end
            end
            S_PUT: begin
                st_waddr = put_addr[STRIP_AW-1:0];
                if (put_fold) begin
                    st_wdata = '{height: fold_h, x: r_last_x};
                end else begin
                    st_wdata = '{height: put_h, x: put_x};
                end
                if (put_req && !put_skip) begin
                    sa_we = r_pa;
                    sb_we = !r_pa;
                end
                seg_we    = put_done;
                seg_wdata = '{bank: !r_pa, len: r_n};
            end
            S_OUT_L1: begin
                seg_raddr = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_sp      <= '0;
            r_o_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_bldg.final_bldg) begin
                            r_fs_lo[0] <= '0;
                            r_fs_hi[0] <= bld_we ? r_cnt[BLD_IDX_W-1:0]
                                                 : BLD_IDX_W'(MAX_BUILDINGS - 1);
                            r_fs_ph[0] <= 1'b0;
                            r_sp       <= FSTK_W'(1);
                            r_cnt      <= '0;
                            r_state    <= S_NODE;
                        end else if (bld_we) begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                end
                S_NODE: begin
                    if (r_sp == '0) begin
                        r_state <= S_OUT_L1;
                    end else if (t_lo_w >= t_hi_w) begin
                        r_lo    <= t_lo_w;
                        r_sp    <= top;
                        r_state <= S_LF_RD;
                    end else if (!r_fs_ph[top]) begin
                        // push right half below left half so the left runs first
                        r_fs_ph[top]      <= 1'b1;
                        r_fs_lo[r_sp]     <= t_mid_w + 1'b1;
                        r_fs_hi[r_sp]     <= t_hi_w;
                        r_fs_ph[r_sp]     <= 1'b0;
                        r_fs_lo[r_sp + 1'b1] <= t_lo_w;
                        r_fs_hi[r_sp + 1'b1] <= t_mid_w;
                        r_fs_ph[r_sp + 1'b1] <= 1'b0;
                        r_sp              <= r_sp + 2'd2;
                    end else begin
                        r_lo    <= t_lo_w;
                        r_mid   <= t_mid_w;
                        r_sp    <= top;
                        r_state <= S_MG_L1;
                    end
                end
                S_LF_RD: r_state <= S_LF_W1;
                S_LF_W1: begin
                    r_bld   <= bld_rdata;
                    r_state <= S_LF_W2;
                end
                S_LF_W2: r_state <= S_NODE;
                S_MG_L1: r_state <= S_MG_L2;
                S_MG_L2: begin
                    r_na    <= seg_rdata.len;
                    r_pa    <= seg_rdata.bank;
                    r_state <= S_MG_L3;
                end
                S_MG_L3: begin
                    r_nb     <= seg_rdata.len;
                    r_pb     <= seg_rdata.bank;
                    r_i      <= '0;
                    r_j      <= '0;
                    r_n      <= '0;
                    r_a_ok   <= 1'b0;
                    r_b_ok   <= 1'b0;
                    r_h1     <= '0;
                    r_h2     <= '0;
                    r_state  <= S_FILL;
                end
                S_FILL: begin
                    if (r_i < r_na && !r_a_ok) begin
                        r_state <= S_LDA;
                    end else if (r_j < r_nb && !r_b_ok) begin
                        r_state <= S_LDB;
                    end else begin
                        r_state <= S_PUT;
                    end
                end
                S_LDA: begin
                    r_a     <= r_pa ? sb_rdata : sa_rdata;
                    r_a_ok  <= 1'b1;
                    r_state <= S_FILL;
                end
                S_LDB: begin
                    r_b     <= r_pb ? sb_rdata : sa_rdata;
                    r_b_ok  <= 1'b1;
                    r_state <= S_FILL;
                end
                S_PUT: begin
                    if (put_done) begin
                        r_state <= S_NODE;
                    end else begin
                        if (r_a_ok && r_b_ok) begin
                            if (put_take_a) begin
                                r_h1 <= r_a.height;
                            end else begin
                                r_h2 <= r_b.height;
                            end
                        end
                        if (put_take_a) begin
                            r_i    <= r_i + 1'b1;
                            r_a_ok <= 1'b0;
                        end else begin
                            r_j    <= r_j + 1'b1;
                            r_b_ok <= 1'b0;
                        end
                        if (put_fold) begin
                            r_last_h <= fold_h;
                        end else if (!put_skip) begin
                            r_last_x <= put_x;
                            r_last_h <= put_h;
                            r_n      <= r_n + 1'b1;
                        end
                        r_state <= S_FILL;
                    end
                end
                S_OUT_L1: r_state <= S_OUT_L2;
                S_OUT_L2: begin
                    r_tot   <= seg_rdata.len;
                    r_obank <= seg_rdata.bank;
                    r_k     <= '0;
                    r_state <= S_OUT_RD;
                end
                S_OUT_RD: r_state <= S_OUT_LD;
                S_OUT_LD: begin
                    r_o_strip <= r_obank ? sb_rdata : sa_rdata;
                    r_o_final <= (r_k + 1'b1 == r_tot);
                    r_o_valid <= 1'b1;
                    r_state   <= S_OUT_WT;
                end
                S_OUT_WT: begin
                    if (o_strip.ready) begin
                        r_o_valid <= 1'b0;
                        if (r_o_final) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_OUT_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_bldg.ready         = (r_state == S_IDLE);
    assign o_strip.valid        = r_o_valid;
    assign o_strip.strip_x      = r_o_strip.x;
    assign o_strip.strip_height = r_o_strip.height;
    assign o_strip.final_strip  = r_o_final;

    sme_ram #(.WIDTH($bits(t_bldg)), .DEPTH(MAX_BUILDINGS)) u_bld_ram (
        .i_clk(i_clk), .i_we(bld_we), .i_waddr(bld_waddr), .i_wdata(bld_wdata),
        .i_raddr(bld_raddr), .o_rdata(bld_rdata)
    );

    sme_ram #(.WIDTH($bits(t_strip)), .DEPTH(STRIP_CAP)) u_bank_a (
        .i_clk(i_clk), .i_we(sa_we), .i_waddr(st_waddr), .i_wdata(st_wdata),
        .i_raddr(st_raddr), .o_rdata(sa_rdata)
    );

    sme_ram #(.WIDTH($bits(t_strip)), .DEPTH(STRIP_CAP)) u_bank_b (
        .i_clk(i_clk), .i_we(sb_we), .i_waddr(st_waddr), .i_wdata(st_wdata),
        .i_raddr(st_raddr), .o_rdata(sb_rdata)
    );

    sme_ram #(.WIDTH($bits(t_seg)), .DEPTH(MAX_BUILDINGS)) u_seg_ram (
        .i_clk(i_clk), .i_we(seg_we), .i_waddr(seg_waddr), .i_wdata(seg_wdata),
        .i_raddr(seg_raddr), .o_rdata(seg_rdata)
    );
endmodule

### sv/sme_checker.sv
// ---------------------------------------------------------------------------
// Skyline merge engine checker
// Port-level checks on loading, emission and the strip channel.
// ---------------------------------------------------------------------------
`include "skyline_merge_engine_macros.svh"

module sme_checker import sme_pkg::*; (
    input logic   i_clk,
    input logic   i_rst_n,
    input logic   i_in_valid,
    input logic   i_in_ready,
    input logic   i_in_final,
    input logic   i_out_valid,
    input logic   i_out_ready,
    input t_coord i_out_x,
    input t_coord i_out_h,
    input logic   i_out_final
);
    // never load while a strip is on offer
    `SME_ASSERT_SAME(a_no_load_on_emit, i_clk, i_rst_n, i_out_valid, !i_in_ready)
    // final building closes the input side
    `SME_ASSERT_NEXT(a_final_closes, i_clk, i_rst_n,
        i_in_valid && i_in_ready && i_in_final, !i_in_ready)
    // nothing follows the final strip straight away
    `SME_ASSERT_NEXT(a_final_strip_ends, i_clk, i_rst_n,
        i_out_valid && i_out_ready && i_out_final, !i_out_valid)
    // stalled strip beat holds
    `SME_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_out_x) && $stable(i_out_h) && $stable(i_out_final))
endmodule

bind skyline_merge_engine sme_checker u_sme_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_bldg.valid),
    .i_in_ready (i_bldg.ready),
    .i_in_final (i_bldg.final_bldg),
    .i_out_valid(o_strip.valid),
    .i_out_ready(o_strip.ready),
    .i_out_x    (o_strip.strip_x),
    .i_out_h    (o_strip.strip_height),
    .i_out_final(o_strip.final_strip)
);

### test/skyline_merge_engine_checker.sv
// ---------------------------------------------------------------------------
// Skyline merge engine checker
// Watches both channels, predicts the skyline of every building set and
// compares each strip beat with the oldest predicted strip.
// ---------------------------------------------------------------------------
module skyline_merge_engine_checker import sme_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    sme_bldg_if  i_bldg,
    sme_strip_if i_strip,
    output int   o_errors,
    output int   o_pending,
    output int   o_strips
);

    typedef t_strip strip_q_t[$];

    typedef struct packed {
        t_coord x;
        t_coord height;
        logic   final_strip;
    } t_exp_strip;

    t_bldg      bldg_mem [MAX_BUILDINGS];
    int         bldg_cnt;
    t_exp_strip sky_q [$];

    // append rule: drop equal height, else merge equal x, else store while room remains
    function automatic void add_strip(inout strip_q_t q, input t_coord x, input t_coord h);
        int n;
        n = q.size();
        if (n > 0) begin
            if (q[n-1].height == h) return;
            if (q[n-1].x == x) begin
                if (h > q[n-1].height) q[n-1].height = h;
                return;
            end
        end
        if (n < STRIP_CAP) q.push_back('{height: h, x: x});
    endfunction

    function automatic strip_q_t skyline_of(int lo, int hi);
        strip_q_t res, a, b;
        int       mid, i, j;
        t_coord   h1, h2;
        res = {};
        if (lo >= hi) begin
            add_strip(res, bldg_mem[lo % MAX_BUILDINGS].left,
                      bldg_mem[lo % MAX_BUILDINGS].height);
            add_strip(res, bldg_mem[lo % MAX_BUILDINGS].right, '0);
            return res;
        end
        mid = (lo + hi) / 2;
        a = skyline_of(lo, mid);
        b = skyline_of(mid + 1, hi);
        i = 0;
        j = 0;
        h1 = '0;
        h2 = '0;
        while (i < a.size() && j < b.size()) begin
            if (a[i].x < b[j].x) begin
                h1 = a[i].height;
                add_strip(res, a[i].x, (h1 > h2) ? h1 : h2);
                i++;
            end else begin
                h2 = b[j].height;
                add_strip(res, b[j].x, (h1 > h2) ? h1 : h2);
                j++;
            end
        end
        for (; i < a.size(); i++) add_strip(res, a[i].x, a[i].height);
        for (; j < b.size(); j++) add_strip(res, b[j].x, b[j].height);
        return res;
    endfunction

    always @(posedge i_clk) begin
        strip_q_t   sky;
        t_exp_strip want;
        if (!i_rst_n) begin
            bldg_cnt  <= 0;
            o_errors  <= 0;
            o_strips  <= 0;
            o_pending <= 0;
        end else begin
            if (i_bldg.valid && i_bldg.ready) begin
                // drop the beat when the store is full, but still honour final
                if (bldg_cnt < MAX_BUILDINGS)
                    bldg_mem[bldg_cnt] = '{right: i_bldg.bldg_right,
                        height: i_bldg.bldg_height, left: i_bldg.bldg_left};
                if (i_bldg.final_bldg) begin
                    sky = skyline_of(0, ((bldg_cnt < MAX_BUILDINGS) ? bldg_cnt + 1
                                                                   : bldg_cnt) - 1);
                    foreach (sky[k])
                        sky_q.push_back('{x: sky[k].x, height: sky[k].height,
                                          final_strip: (k == sky.size() - 1)});
                    bldg_cnt <= 0;
                end else if (bldg_cnt < MAX_BUILDINGS) begin
                    bldg_cnt <= bldg_cnt + 1;
                end
            end
            if (i_strip.valid && i_strip.ready) begin
                o_strips <= o_strips + 1;
                if (sky_q.size() == 0) begin
                    if (o_errors < 10)
                        $display("unexpected strip x=%0d h=%0d final=%0b",
                                 i_strip.strip_x, i_strip.strip_height, i_strip.final_strip);
                    o_errors <= o_errors + 1;
                end else begin
                    want = sky_q.pop_front();
                    if (want.x !== i_strip.strip_x || want.height !== i_strip.strip_height
                        || want.final_strip !== i_strip.final_strip) begin
                        if (o_errors < 10)
                            $display("strip mismatch: exp x=%0d h=%0d f=%0b got x=%0d h=%0d f=%0b",
                                     want.x, want.height, want.final_strip, i_strip.strip_x,
                                     i_strip.strip_height, i_strip.final_strip);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            o_pending <= sky_q.size();
        end
    end

endmodule

### test/skyline_merge_engine_tb.sv
// ---------------------------------------------------------------------------
// Skyline merge engine testbench
// Sends directed and random building sets under varied back-pressure and
// leaves the strip checking to the checker beside the block.
// ---------------------------------------------------------------------------
module skyline_merge_engine_tb;
    import sme_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    logic i_clk;
    logic i_rst_n;
    int   errors, pending, strips;
    int   phase;
    int   cycles;
    int   items_sent, sets_sent;

    sme_bldg_if  bldg_ch ();
    sme_strip_if strip_ch ();

    skyline_merge_engine uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_bldg  (bldg_ch),
        .o_strip (strip_ch)
    );

    skyline_merge_engine_checker chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_bldg    (bldg_ch),
        .i_strip   (strip_ch),
        .o_errors  (errors),
        .o_pending (pending),
        .o_strips  (strips)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout");
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver stalls in the stall phases
    always @(posedge i_clk) begin
        case (phase)
            2:       strip_ch.ready <= ($urandom_range(99) >= 86);
            3:       strip_ch.ready <= ($urandom_range(99) >= 19);
            default: strip_ch.ready <= 1'b1;
        endcase
    end

    task automatic send_bldg(t_coord l, t_coord h, t_coord r, logic last);
        int  gap_pct;
        logic rdy;
        gap_pct = (phase == 1) ? 86 : (phase == 3) ? 19 : 0;
        if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            bldg_ch.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < gap_pct) @(posedge i_clk);
        end
        bldg_ch.valid       <= 1'b1;
        bldg_ch.bldg_left   <= l;
        bldg_ch.bldg_height <= h;
        bldg_ch.bldg_right  <= r;
        bldg_ch.final_bldg  <= last;
        do begin
            @(negedge i_clk);
            rdy = bldg_ch.ready;
            @(posedge i_clk);
        end while (!rdy);
        items_sent++;
        if (last) sets_sent++;
    endtask

    task automatic send_random_set();
        int     n, mode;
        t_coord l, h, r;
        n = ($urandom_range(9) == 0) ? $urandom_range(18, 15) : $urandom_range(6, 1);
        mode = $urandom_range(2);
        for (int k = 0; k < n; k++) begin
            if (mode == 0) begin
                // tight ranges to force shared x and equal heights
                l = t_coord'($urandom_range(24));
                r = t_coord'(l + $urandom_range(8));
                h = t_coord'($urandom_range(3));
            end else if (mode == 1) begin
                l = t_coord'($urandom_range(1000));
                r = t_coord'(l + $urandom_range(300));
                h = t_coord'($urandom_range(500));
            end else begin
                l = t_coord'($urandom);
                r = t_coord'($urandom);
                h = t_coord'($urandom);
            end
            send_bldg(l, h, r, k == n - 1);
        end
    endtask

    initial begin
        phase      = 0;
        cycles     = 0;
        items_sent = 0;
        sets_sent  = 0;
        i_rst_n             = 1'b0;
        bldg_ch.valid       = 1'b0;
        bldg_ch.bldg_left   = '0;
        bldg_ch.bldg_height = '0;
        bldg_ch.bldg_right  = '0;
        bldg_ch.final_bldg  = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, degenerate buildings, shared x, full store
        send_bldg(16'd0, 16'hFFFF, 16'hFFFF, 1'b1);
        send_bldg(16'd5, 16'd0, 16'd3, 1'b1);
        send_bldg(16'd10, 16'd7, 16'd10, 1'b1);
        send_bldg(16'd2, 16'd9, 16'd8, 1'b0);
        send_bldg(16'd2, 16'd9, 16'd8, 1'b0);
        send_bldg(16'd2, 16'd12, 16'd5, 1'b1);
        send_bldg(16'hFFFF, 16'd1, 16'd0, 1'b1);
        for (int k = 0; k < 17; k++)
            send_bldg(t_coord'(k * 3), t_coord'((k * 7) % 5), t_coord'(k * 3 + 6), k == 16);

        while (items_sent < 160) begin
            phase = (items_sent < 55) ? 0 : (items_sent < 90) ? 1
                  : (items_sent < 125) ? 2 : 3;
            send_random_set();
        end
        bldg_ch.valid <= 1'b0;

        // let the prediction of the last set settle before polling
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        $display("sent %0d buildings in %0d sets, checked %0d strips",
                 items_sent, sets_sent, strips);
        if (errors == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
